FILE: rtl/fvp_pkg.sv
// ----------------------------------------------------------------------------
// fvp_pkg - shared types and constants of the voltage to pwm datapath
// polynomial sine coefficients, register indexes and the configuration bundle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fvp_pkg;

  // odd taylor terms of sin(pi/2 * x), q30
  localparam logic [30:0] SIN_A     = 31'd1686629713;
  localparam logic [29:0] SIN_B     = 30'd693598668;
  localparam logic [26:0] SIN_C     = 27'd85569306;
  localparam logic [22:0] SIN_D     = 23'd5026995;
  localparam logic [30:0] Q30_ONE   = 31'd1073741824;

  // quarter turn of the 16-bit angle
  localparam logic [14:0] QUARTER   = 15'd16384;

  // sqrt(3) in q16
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;

  // phase voltage after clamp, units of 2^-16 v
  localparam int unsigned PH_W      = 24;
  // compare value width
  localparam int unsigned CMP_W     = 16;

  localparam logic [15:0] SUPPLY_RST = 16'd3072;
  localparam logic [15:0] LIMIT_RST  = 16'd3072;
  localparam logic [15:0] FULL_RST   = 16'd2400;

  typedef enum logic [1:0] {
    REG_SUPPLY = 2'd0,
    REG_LIMIT  = 2'd1,
    REG_FULL   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] supply;
    logic [15:0] limit;
    logic [15:0] full;
  } cfg_t;

endpackage

FILE: rtl/foc_voltage_to_pwm.sv
// ----------------------------------------------------------------------------
// foc_voltage_to_pwm - quadrature voltage command to three pwm compare values
// clamp, inverse park/clarke with half-supply offset, duty scaling
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata / payload (lowest bit first)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | uq[15:0] signed q7.8, angle[31:16] 65536 = turn
//  m_axis   | out       | compare_a[15:0], compare_b[31:16], compare_c[47:32]
//  cfg      | in        | cfg_index_i: 0 supply, 1 phase limit, 2 full scale
//
//  one request per cycle while the output is drained; a taken request passes
//  7 trig stages, 4 transform stages and 9 divide stages before it leaves
//  of the 9 divide stages, 8 produce two quotient bits each, per phase
//  reset clears every stage valid and loads the registers with 12 v, 12 v, 2400
//  each stage holds while the next one is full and stalled; empty stages
//  close up, so requests keep coming in while a result waits on m_axis
//  cfg_ready_o is always high; write only while no request is in flight
//
`timescale 1ns / 1ps

module foc_voltage_to_pwm #(
  parameter int unsigned SINE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream: uq [15:0], angle [31:16]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // master stream: compare_a [15:0], compare_b [31:16], compare_c [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned SW = SINE_BITS + 2;

  logic [15:0] supply_q, limit_q, full_q;
  fvp_pkg::cfg_t cfg_w;

  // trig to transform
  logic                 trig_valid, trig_ready;
  logic signed [16:0]   trig_u;
  logic signed [SW-1:0] trig_sin, trig_cos;

  // transform to divider
  logic                                 mix_valid, mix_ready;
  logic [2:0][fvp_pkg::PH_W-1:0]        mix_ph;

  logic [2:0][fvp_pkg::CMP_W-1:0]       cmp;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= fvp_pkg::SUPPLY_RST;
      limit_q  <= fvp_pkg::LIMIT_RST;
      full_q   <= fvp_pkg::FULL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fvp_pkg::reg_idx_e'(cfg_index_i))
        fvp_pkg::REG_SUPPLY: supply_q <= cfg_data_i;
        fvp_pkg::REG_LIMIT:  limit_q  <= cfg_data_i;
        fvp_pkg::REG_FULL:   full_q   <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg_w.supply = supply_q;
  assign cfg_w.limit  = limit_q;
  assign cfg_w.full   = full_q;

  // sine and cosine, command carried in q.9 and clamped to +-supply/2
  fvp_trig #(
    .SINE_BITS (SINE_BITS)
  ) u_trig (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .uq_i     ($signed(s_axis_tdata[15:0])),
    .angle_i  (s_axis_tdata[31:16]),
    .supply_i (supply_q),
    .valid_o  (trig_valid),
    .ready_i  (trig_ready),
    .u_o      (trig_u),
    .sin_o    (trig_sin),
    .cos_o    (trig_cos)
  );

  // phase voltages with half-supply offset, clamped to the phase limit
  fvp_mix #(
    .SINE_BITS (SINE_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trig_valid),
    .ready_o (trig_ready),
    .u_i     (trig_u),
    .sin_i   (trig_sin),
    .cos_i   (trig_cos),
    .cfg_i   (cfg_w),
    .valid_o (mix_valid),
    .ready_i (mix_ready),
    .ph_o    (mix_ph)
  );

  // duty times full scale; last stage is the output register
  fvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (mix_ready),
    .ph_i    (mix_ph),
    .cfg_i   (cfg_w),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .cmp_o   (cmp)
  );

  assign m_axis_tdata = {cmp[2], cmp[1], cmp[0]};

  // backpressure reaches the input only through a full pipe held at the output
  a_stall_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled without a held result");

endmodule

FILE: rtl/fvp_trig.sv
// ----------------------------------------------------------------------------
// fvp_trig - pipelined sine and cosine of the electrical angle
// quarter-wave polynomial in two lanes, command clamp carried alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvp_trig #(
  parameter int unsigned SINE_BITS = 16,
  localparam int unsigned SW = SINE_BITS + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [15:0]   uq_i,
  input  logic [15:0]          angle_i,
  input  logic [15:0]          supply_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [16:0]   u_o,
  output logic signed [SW-1:0] sin_o,
  output logic signed [SW-1:0] cos_o
);

  localparam int unsigned NS = 7;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< SINE_BITS;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  logic [14:0]          x_q   [2][5];
  logic                 neg_q [2][6];
  logic [30:0]          sq_q  [2][3];
  logic [26:0]          t1_q  [2];
  logic [29:0]          t2_q  [2];
  logic [30:0]          t3_q  [2];
  logic [30:0]          s_q   [2];
  logic signed [SW-1:0] y_q   [2];
  logic signed [16:0]   u_q   [NS];

  logic signed [16:0] u2_w, sup_w, u0_w;
  logic [15:0]        ang_w [2];
  logic [14:0]        x0_w  [2];
  logic [29:0]        xx_w  [2];
  logic [53:0]        pd_w  [2];
  logic [57:0]        pc_w  [2];
  logic [60:0]        pb_w  [2];
  logic [45:0]        pa_w  [2];
  logic [30:0]        sc_w  [2];
  logic [31:0]        rnd_w [2];
  logic [SINE_BITS:0] mag_w [2];

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    u2_w  = {uq_i, 1'b0};
    sup_w = {1'b0, supply_i};
    if (u2_w > sup_w) begin
      u0_w = sup_w;
    end else if (u2_w < -sup_w) begin
      u0_w = -sup_w;
    end else begin
      u0_w = u2_w;
    end
    for (int l = 0; l < 2; l++) begin
      // lane 1 is the cosine, a quarter turn ahead
      ang_w[l] = (l == 0) ? angle_i : angle_i + 16'(fvp_pkg::QUARTER);
      x0_w[l]  = ang_w[l][14] ? fvp_pkg::QUARTER - {1'b0, ang_w[l][13:0]}
                              : {1'b0, ang_w[l][13:0]};
      xx_w[l]  = 30'(x_q[l][0]) * 30'(x_q[l][0]);
      pd_w[l]  = 54'(fvp_pkg::SIN_D) * 54'(sq_q[l][0]);
      pc_w[l]  = 58'(t1_q[l]) * 58'(sq_q[l][1]);
      pb_w[l]  = 61'(t2_q[l]) * 61'(sq_q[l][2]);
      pa_w[l]  = 46'(t3_q[l]) * 46'(x_q[l][4]);
      sc_w[l]  = (s_q[l] > fvp_pkg::Q30_ONE) ? fvp_pkg::Q30_ONE : s_q[l];
      rnd_w[l] = (32'(sc_w[l]) + (32'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
      mag_w[l] = (SINE_BITS + 1)'(rnd_w[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q[0] <= u0_w;
      for (int l = 0; l < 2; l++) begin
        x_q[l][0]   <= x0_w[l];
        neg_q[l][0] <= ang_w[l][15];
      end
    end
    if (en[1]) begin
      u_q[1] <= u_q[0];
      for (int l = 0; l < 2; l++) begin
        sq_q[l][0]  <= {xx_w[l][28:0], 2'b00};
        x_q[l][1]   <= x_q[l][0];
        neg_q[l][1] <= neg_q[l][0];
      end
    end
    if (en[2]) begin
      u_q[2] <= u_q[1];
      for (int l = 0; l < 2; l++) begin
        t1_q[l]     <= fvp_pkg::SIN_C - {3'b000, pd_w[l][53:30]};
        sq_q[l][1]  <= sq_q[l][0];
        x_q[l][2]   <= x_q[l][1];
        neg_q[l][2] <= neg_q[l][1];
      end
    end
    if (en[3]) begin
      u_q[3] <= u_q[2];
      for (int l = 0; l < 2; l++) begin
        t2_q[l]     <= fvp_pkg::SIN_B - {2'b00, pc_w[l][57:30]};
        sq_q[l][2]  <= sq_q[l][1];
        x_q[l][3]   <= x_q[l][2];
        neg_q[l][3] <= neg_q[l][2];
      end
    end
    if (en[4]) begin
      u_q[4] <= u_q[3];
      for (int l = 0; l < 2; l++) begin
        t3_q[l]     <= fvp_pkg::SIN_A - pb_w[l][60:30];
        x_q[l][4]   <= x_q[l][3];
        neg_q[l][4] <= neg_q[l][3];
      end
    end
    if (en[5]) begin
      u_q[5] <= u_q[4];
      for (int l = 0; l < 2; l++) begin
        s_q[l]      <= pa_w[l][44:14];
        neg_q[l][5] <= neg_q[l][4];
      end
    end
    if (en[6]) begin
      u_q[6] <= u_q[5];
      for (int l = 0; l < 2; l++) begin
        y_q[l] <= neg_q[l][5] ? -$signed({1'b0, mag_w[l]}) : $signed({1'b0, mag_w[l]});
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];
  assign u_o     = u_q[NS-1];
  assign sin_o   = y_q[0];
  assign cos_o   = y_q[1];

  a_sin_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sin_o <= ONE_S && sin_o >= -ONE_S))
    else $error("sine beyond unit magnitude");

  a_cos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cos_o <= ONE_S && cos_o >= -ONE_S))
    else $error("cosine beyond unit magnitude");

  a_u_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (u_o != 17'h10000))
    else $error("command escaped the supply clamp");

endmodule

FILE: rtl/fvp_mix.sv
// ----------------------------------------------------------------------------
// fvp_mix - inverse park and clarke transforms with phase clamp
// three phase voltages, offset by half supply, clamped and scaled to 2^-16 v
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvp_mix #(
  parameter int unsigned SINE_BITS = 16,
  localparam int unsigned SW = SINE_BITS + 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [16:0]                 u_i,
  input  logic signed [SW-1:0]               sin_i,
  input  logic signed [SW-1:0]               cos_i,
  input  fvp_pkg::cfg_t                      cfg_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [2:0][fvp_pkg::PH_W-1:0]      ph_o
);

  localparam int unsigned NS = 4;
  localparam int unsigned PW = SW + 17;
  localparam int unsigned QW = PW + 18;
  localparam int unsigned VW = SINE_BITS + 38;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  logic signed [PW-1:0] p_q [2];
  logic signed [PW-1:0] uc_q;
  logic signed [QW-1:0] q_q;
  logic signed [VW-1:0] sum_q [3];
  logic [fvp_pkg::PH_W-1:0] ph_q [3];

  logic signed [PW-1:0] p_w, uc_w;
  logic signed [QW-1:0] q_w;
  logic signed [VW-1:0] off_w, lim_w, pe_w, qe_w;
  logic signed [VW-1:0] sum_w [3];
  logic [fvp_pkg::PH_W-1:0] ph_w [3];

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    p_w   = PW'(u_i) * PW'(sin_i);
    uc_w  = PW'(u_i) * PW'(cos_i);
    q_w   = QW'(uc_q) * QW'($signed({1'b0, fvp_pkg::SQRT3_Q16}));
    off_w = $signed(VW'(cfg_i.supply) << (17 + SINE_BITS));
    lim_w = $signed(VW'(cfg_i.limit) << (18 + SINE_BITS));
    pe_w  = VW'(p_q[1]);
    qe_w  = VW'(q_q);
    // alpha = -u*sin, beta = u*cos
    sum_w[0] = off_w - (pe_w <<< 17);
    sum_w[1] = off_w + qe_w + (pe_w <<< 16);
    sum_w[2] = off_w + (pe_w <<< 16) - qe_w;
    for (int l = 0; l < 3; l++) begin
      if (sum_q[l] < 0) begin
        ph_w[l] = '0;
      end else if (sum_q[l] > lim_w) begin
        ph_w[l] = {cfg_i.limit, 8'h00};
      end else begin
        ph_w[l] = sum_q[l][10 + SINE_BITS +: fvp_pkg::PH_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q[0] <= p_w;
      uc_q   <= uc_w;
    end
    if (en[1]) begin
      p_q[1] <= p_q[0];
      q_q    <= q_w;
    end
    if (en[2]) begin
      for (int l = 0; l < 3; l++) begin
        sum_q[l] <= sum_w[l];
      end
    end
    if (en[3]) begin
      for (int l = 0; l < 3; l++) begin
        ph_q[l] <= ph_w[l];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];
  assign ph_o    = {ph_q[2], ph_q[1], ph_q[0]};

endmodule

FILE: rtl/fvp_div.sv
// ----------------------------------------------------------------------------
// fvp_div - duty scaling, phase voltage times full scale over supply
// three lanes of pipelined restoring division, two quotient bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvp_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [2:0][fvp_pkg::PH_W-1:0]       ph_i,
  input  fvp_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [2:0][fvp_pkg::CMP_W-1:0]      cmp_o
);

  localparam int unsigned QB   = fvp_pkg::CMP_W;
  localparam int unsigned STEP = 2;
  localparam int unsigned NDS  = QB / STEP;
  localparam int unsigned NS   = NDS + 1;
  localparam int unsigned RW   = fvp_pkg::PH_W;
  localparam int unsigned NW   = RW + QB;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  logic [RW-1:0] r_q   [3][NDS];
  logic [QB-1:0] q_q   [3][NDS];
  logic [QB-1:0] nl_q  [3][NDS];
  logic          sat_q [3][NDS];
  logic [QB-1:0] cmp_q [3];

  logic [RW-1:0] denom_w;
  logic [NW-1:0] n_w   [3];
  logic [RW-1:0] nr_w  [3][NDS];
  logic [QB-1:0] nq_w  [3][NDS];
  logic [QB-1:0] nn_w  [3][NDS];
  logic [RW-1:0] rr;
  logic [RW:0]   rx;
  logic [QB-1:0] qq, nn;

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    denom_w = {cfg_i.supply, 8'h00};
    rr = '0;
    rx = '0;
    qq = '0;
    nn = '0;
    for (int l = 0; l < 3; l++) begin
      n_w[l] = NW'(ph_i[l]) * NW'(cfg_i.full);
      for (int k = 0; k < NDS; k++) begin
        rr = r_q[l][k];
        qq = q_q[l][k];
        nn = nl_q[l][k];
        for (int j = 0; j < STEP; j++) begin
          rx = {rr, nn[QB-1]};
          nn = nn << 1;
          if (rx >= {1'b0, denom_w}) begin
            rx = rx - {1'b0, denom_w};
            qq = {qq[QB-2:0], 1'b1};
          end else begin
            qq = {qq[QB-2:0], 1'b0};
          end
          rr = rx[RW-1:0];
        end
        nr_w[l][k] = rr;
        nq_w[l][k] = qq;
        nn_w[l][k] = nn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int l = 0; l < 3; l++) begin
        // upper dividend bits stay below the divisor unless saturated
        r_q[l][0]   <= n_w[l][NW-1:QB];
        nl_q[l][0]  <= n_w[l][QB-1:0];
        q_q[l][0]   <= '0;
        sat_q[l][0] <= (ph_i[l] >= denom_w);
      end
    end
    for (int k = 1; k < NDS; k++) begin
      if (en[k]) begin
        for (int l = 0; l < 3; l++) begin
          r_q[l][k]   <= nr_w[l][k-1];
          q_q[l][k]   <= nq_w[l][k-1];
          nl_q[l][k]  <= nn_w[l][k-1];
          sat_q[l][k] <= sat_q[l][k-1];
        end
      end
    end
    if (en[NDS]) begin
      for (int l = 0; l < 3; l++) begin
        if (cfg_i.supply == '0) begin
          cmp_q[l] <= '0;
        end else if (sat_q[l][NDS-1]) begin
          cmp_q[l] <= cfg_i.full;
        end else begin
          cmp_q[l] <= nq_w[l][NDS-1];
        end
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];
  assign cmp_o   = {cmp_q[2], cmp_q[1], cmp_q[0]};

endmodule
